// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Morse key decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MKD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MKD_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/mkd_pkg.sv -----
// ----------------------------------------------------------------------------
// Morse key decoder package
// Codes, shared types and the Morse tree character table.
// ----------------------------------------------------------------------------
package mkd_pkg;

   localparam int CFG_W       = 16;
   localparam int CHAR_W      = 7;
   localparam int ROM_ADDR_W  = 8;
   localparam int TREE_NODES  = 63;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CHAR_W-1:0] BAD_CHAR = 7'h23;

   // Preorder layout: dot steps to the next entry, dash skips the left subtree.
   localparam logic [TREE_NODES*8-1:0] TREE_STR =
      "#EISH54V#3UF####2ARL#####WP##J#1TNDB6#X##KC##Y##MGZ7#Q##O#8##90";

   localparam logic [CSR_INDEX_W-1:0] CSR_DOT_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LETTER_GAP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_GAP   = 2'd2;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_DOT    = 3'd1,
      EV_DASH   = 3'd2,
      EV_LETTER = 3'd3,
      EV_WORD   = 3'd4
   } event_type;

   typedef enum logic [1:0] {
      ST_NONE  = 2'd0,
      ST_VALID = 2'd1,
      ST_CHAR  = 2'd2,
      ST_ERROR = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      PH_IDLE_WORD   = 5'b00001,
      PH_WAIT_WORD   = 5'b00010,
      PH_WAIT_LETTER = 5'b00100,
      PH_SHORT       = 5'b01000,
      PH_LONG        = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [CFG_W-1:0] dot_limit;
      logic [CFG_W-1:0] letter_gap;
      logic [CFG_W-1:0] word_gap;
   } cfg_type;

   typedef struct packed {
      event_type         key_event;
      status_type        decode_status;
      logic [CHAR_W-1:0] decoded_char;
   } result_type;

   function automatic logic [CHAR_W-1:0] tree_char(input logic [ROM_ADDR_W-1:0] idx);
      logic [7:0] byte_val;
      byte_val = 8'h00;
      if (int'(idx) >= TREE_NODES) begin
         return BAD_CHAR;
      end
      byte_val = TREE_STR[(TREE_NODES - 1 - int'(idx)) * 8 +: 8];
      return byte_val[CHAR_W-1:0];
   endfunction

endpackage

// ----- rtl/mkd_if.sv -----
// ----------------------------------------------------------------------------
// Morse key decoder channels
// Valid/ready channel bundles for tick items and decode results.
// ----------------------------------------------------------------------------
interface mkd_req_if;
   logic valid;
   logic ready;
   logic key_pressed;
   logic key_released;

   modport source (output valid, output key_pressed, output key_released, input ready);
   modport sink   (input valid, input key_pressed, input key_released, output ready);
endinterface

interface mkd_rsp_if;
   logic                          valid;
   logic                          ready;
   mkd_pkg::event_type            key_event;
   mkd_pkg::status_type           decode_status;
   logic [mkd_pkg::CHAR_W-1:0]    decoded_char;

   modport source (output valid, output key_event, output decode_status,
                   output decoded_char, input ready);
   modport sink   (input valid, input key_event, input decode_status,
                   input decoded_char, output ready);
endinterface

// ----- rtl/morse_key_decoder.sv -----
// ----------------------------------------------------------------------------
// Morse key decoder
// Times key presses into dots and dashes, detects letter and word gaps, and
// walks the Morse tree to decode characters.
//
//   Channel  Dir  Payload                                   Transfer
//   req      in   key_pressed, key_released                 valid && ready
//   rsp      out  key_event, decode_status, decoded_char    valid && ready
//   csr      in   csr_index, csr_wdata                      csr_write_en
//
// One tick is taken every cycle unless the stages are full. The keyer state and
// the tree ROM read are registered together at the tick's transfer, and the
// letter decode fills the output register once the keying stage can move, from
// which the result transfers.
// Reset loads dot_limit 25, letter_gap 50 and word_gap 100 and starts the
// keyer waiting for a word at the tree root; there is no clearing pass.
// A stalled rsp holds the output register; req keeps flowing until the
// keying stage register is also full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module morse_key_decoder #(
   parameter int TREE_LEVELS = 6,
   parameter int TIMER_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   mkd_req_if.sink                           req,
   mkd_rsp_if.source                         rsp,
   input  logic                              csr_write_en,
   input  logic [mkd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mkd_pkg::CFG_W-1:0]         csr_wdata
);

   mkd_pkg::cfg_type        cfg_ff;
   mkd_pkg::result_type     key_result;
   logic [TREE_LEVELS-1:0]  node_index;
   logic [mkd_pkg::CHAR_W-1:0] rom_data;
   logic                    accept;
   logic                    s1_move;
   logic                    s1_valid_ff;
   mkd_pkg::result_type     s1_ff;
   logic                    rsp_valid_ff;
   mkd_pkg::result_type     out_ff, out_in;

   assign s1_move   = !rsp_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || s1_move;
   assign accept    = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dot_limit  <= 16'd25;
         cfg_ff.letter_gap <= 16'd50;
         cfg_ff.word_gap   <= 16'd100;
      end else if (csr_write_en) begin
         unique case (csr_index)
            mkd_pkg::CSR_DOT_LIMIT:  cfg_ff.dot_limit  <= csr_wdata;
            mkd_pkg::CSR_LETTER_GAP: cfg_ff.letter_gap <= csr_wdata;
            mkd_pkg::CSR_WORD_GAP:   cfg_ff.word_gap   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   mkd_keyer #(
      .TREE_LEVELS (TREE_LEVELS),
      .TIMER_BITS  (TIMER_BITS)
   ) u_keyer (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .key_pressed  (req.key_pressed),
      .key_released (req.key_released),
      .cfg          (cfg_ff),
      .result       (key_result),
      .node_index   (node_index)
   );

   mkd_tree_rom u_tree_rom (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (mkd_pkg::ROM_ADDR_W'(node_index)),
      .rd_data (rom_data)
   );

   always_comb begin
      out_in = s1_ff;
      if (s1_ff.key_event == mkd_pkg::EV_LETTER) begin
         if (rom_data == mkd_pkg::BAD_CHAR) begin
            out_in.decode_status = mkd_pkg::ST_ERROR;
            out_in.decoded_char  = mkd_pkg::BAD_CHAR;
         end else begin
            out_in.decode_status = mkd_pkg::ST_CHAR;
            out_in.decoded_char  = rom_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_valid_ff && s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= key_result;
      end
      if (s1_valid_ff && s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.key_event     = out_ff.key_event;
   assign rsp.decode_status = out_ff.decode_status;
   assign rsp.decoded_char  = out_ff.decoded_char;

   `MKD_ASSERT_NXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_move, s1_valid_ff && $stable(s1_ff), "keying stage lost its item under stall")
   `MKD_ASSERT_IMP(a_no_decode_step, clock, reset, rsp_valid_ff && (out_ff.key_event == mkd_pkg::EV_NONE || out_ff.key_event == mkd_pkg::EV_WORD), out_ff.decode_status == mkd_pkg::ST_NONE && out_ff.decoded_char == '0, "decode data without a decode step")

endmodule

// ----- rtl/mkd_tree_rom.sv -----
// ----------------------------------------------------------------------------
// Morse tree ROM
// Character table of the Morse tree with a registered read port.
// ----------------------------------------------------------------------------
module mkd_tree_rom (
   input  logic                              clock,
   input  logic                              rd_en,
   input  logic [mkd_pkg::ROM_ADDR_W-1:0]    rd_addr,
   output logic [mkd_pkg::CHAR_W-1:0]        rd_data
);

   logic [mkd_pkg::CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mkd_pkg::tree_char(rd_addr);
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mkd_keyer.sv -----
// ----------------------------------------------------------------------------
// Morse keyer
// Keying state machine with press and silence timers, and the tree walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mkd_keyer #(
   parameter int TREE_LEVELS = 6,
   parameter int TIMER_BITS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        key_pressed,
   input  logic                        key_released,
   input  mkd_pkg::cfg_type            cfg,
   output mkd_pkg::result_type         result,
   output logic [TREE_LEVELS-1:0]      node_index
);

   localparam int DEPTH_W = $clog2(TREE_LEVELS);
   localparam logic [DEPTH_W-1:0] LAST_DEPTH = DEPTH_W'(TREE_LEVELS - 1);

   mkd_pkg::phase_type      phase_ff, phase_in;
   logic [TIMER_BITS-1:0]   press_ff, press_in;
   logic [TIMER_BITS-1:0]   letter_ff, letter_in;
   logic [TIMER_BITS-1:0]   word_ff, word_in;
   logic [TREE_LEVELS-1:0]  node_ff, node_in;
   logic [DEPTH_W-1:0]      depth_ff, depth_in;
   logic [TIMER_BITS-1:0]   press_dec;
   logic [TIMER_BITS-1:0]   letter_dec;
   logic [TIMER_BITS-1:0]   word_dec;
   mkd_pkg::event_type      ev;

   assign press_dec  = press_ff - TIMER_BITS'(1);
   assign letter_dec = letter_ff - TIMER_BITS'(1);
   assign word_dec   = word_ff - TIMER_BITS'(1);

   always_comb begin
      phase_in  = phase_ff;
      press_in  = press_ff;
      letter_in = letter_ff;
      word_in   = word_ff;
      ev        = mkd_pkg::EV_NONE;
      unique case (phase_ff)
         mkd_pkg::PH_WAIT_WORD: begin
            word_in = word_dec;
            if (word_dec == '0) begin
               ev       = mkd_pkg::EV_WORD;
               phase_in = mkd_pkg::PH_IDLE_WORD;
            end else if (key_pressed) begin
               press_in = TIMER_BITS'(cfg.dot_limit);
               phase_in = mkd_pkg::PH_SHORT;
            end
         end
         mkd_pkg::PH_WAIT_LETTER: begin
            letter_in = letter_dec;
            if (letter_dec == '0) begin
               ev       = mkd_pkg::EV_LETTER;
               phase_in = mkd_pkg::PH_WAIT_WORD;
            end else if (key_pressed) begin
               press_in = TIMER_BITS'(cfg.dot_limit);
               phase_in = mkd_pkg::PH_SHORT;
            end
         end
         mkd_pkg::PH_SHORT: begin
            press_in = press_dec;
            if (press_dec == '0) begin
               phase_in = mkd_pkg::PH_LONG;
            end else if (key_released) begin
               word_in   = TIMER_BITS'(cfg.word_gap);
               letter_in = TIMER_BITS'(cfg.letter_gap);
               ev        = mkd_pkg::EV_DOT;
               phase_in  = mkd_pkg::PH_WAIT_LETTER;
            end
         end
         mkd_pkg::PH_LONG: begin
            if (key_released) begin
               word_in   = TIMER_BITS'(cfg.word_gap);
               letter_in = TIMER_BITS'(cfg.letter_gap);
               ev        = mkd_pkg::EV_DASH;
               phase_in  = mkd_pkg::PH_WAIT_LETTER;
            end
         end
         default: begin
            if (key_pressed) begin
               press_in = TIMER_BITS'(cfg.dot_limit);
               phase_in = mkd_pkg::PH_SHORT;
            end else begin
               phase_in = mkd_pkg::PH_IDLE_WORD;
            end
         end
      endcase
   end

   always_comb begin
      node_in                = node_ff;
      depth_in               = depth_ff;
      result.key_event       = ev;
      result.decode_status   = mkd_pkg::ST_NONE;
      result.decoded_char    = '0;
      if (ev == mkd_pkg::EV_DOT || ev == mkd_pkg::EV_DASH) begin
         if (depth_ff >= LAST_DEPTH) begin
            result.decode_status = mkd_pkg::ST_ERROR;
            result.decoded_char  = mkd_pkg::BAD_CHAR;
            node_in              = '0;
            depth_in             = '0;
         end else begin
            if (ev == mkd_pkg::EV_DOT) begin
               node_in = node_ff + TREE_LEVELS'(1);
            end else begin
               node_in = node_ff + (TREE_LEVELS'(1) << (LAST_DEPTH - depth_ff));
            end
            depth_in             = depth_ff + DEPTH_W'(1);
            result.decode_status = mkd_pkg::ST_VALID;
         end
      end else if (ev == mkd_pkg::EV_LETTER) begin
         node_in  = '0;
         depth_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= mkd_pkg::PH_IDLE_WORD;
         press_ff  <= '0;
         letter_ff <= '0;
         word_ff   <= '0;
         node_ff   <= '0;
         depth_ff  <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         press_ff  <= press_in;
         letter_ff <= letter_in;
         word_ff   <= word_in;
         node_ff   <= node_in;
         depth_ff  <= depth_in;
      end
   end

   assign node_index = node_ff;

   `MKD_ASSERT_IMP(a_depth_bound, clock, reset, 1'b1, depth_ff <= LAST_DEPTH, "tree depth out of range")
   `MKD_ASSERT_NXT(a_letter_to_root, clock, reset, accept && ev == mkd_pkg::EV_LETTER, node_ff == '0 && depth_ff == '0, "walk did not return to the root after a letter")

endmodule

// ----- dv/morse_key_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse key decoder testbench
// Drives key ticks through the request channel and checks every decode
// result against an in-bench model of the keyer timers and the Morse tree
// or a typed result. A short scripted sequence covers reset behavior, tree
// overflow and lost presses. Random keying then runs under several timer
// settings, with random gaps on both channels in all but the last one.
// ----------------------------------------------------------------------------
module morse_key_decoder_tb;

   localparam int TREE_LEVELS   = 6;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 200000;

   localparam mkd_pkg::result_type QUIET_TICK =
      '{mkd_pkg::EV_NONE, mkd_pkg::ST_NONE, 7'd0};
   localparam mkd_pkg::result_type OVERFLOW_DOT =
      '{mkd_pkg::EV_DOT, mkd_pkg::ST_ERROR, mkd_pkg::BAD_CHAR};
   localparam mkd_pkg::result_type ROOT_LETTER =
      '{mkd_pkg::EV_LETTER, mkd_pkg::ST_ERROR, mkd_pkg::BAD_CHAR};
   localparam mkd_pkg::result_type WORD_END =
      '{mkd_pkg::EV_WORD, mkd_pkg::ST_NONE, 7'd0};

   localparam logic [mkd_pkg::CSR_INDEX_W-1:0] DL = mkd_pkg::CSR_DOT_LIMIT;
   localparam logic [mkd_pkg::CSR_INDEX_W-1:0] LG = mkd_pkg::CSR_LETTER_GAP;
   localparam logic [mkd_pkg::CSR_INDEX_W-1:0] WG = mkd_pkg::CSR_WORD_GAP;

   typedef struct {
      bit                                  csr;
      logic [mkd_pkg::CSR_INDEX_W-1:0]     idx;
      logic [mkd_pkg::CFG_W-1:0]           val;
      bit                                  down;
      bit                                  up;
      bit                                  typed;
      mkd_pkg::result_type                 want;
   } key_row_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_write_en;
   logic [mkd_pkg::CSR_INDEX_W-1:0]   csr_index;
   logic [mkd_pkg::CFG_W-1:0]         csr_wdata;

   mkd_req_if req_ch ();
   mkd_rsp_if rsp_ch ();

   // Timer settings and keyer state as the block should hold them.
   logic [mkd_pkg::CFG_W-1:0] dot_lim;
   logic [mkd_pkg::CFG_W-1:0] let_gap;
   logic [mkd_pkg::CFG_W-1:0] wrd_gap;
   mkd_pkg::phase_type        kp_phase;
   logic [15:0]               press_left;
   logic [15:0]               letter_left;
   logic [15:0]               word_left;
   logic [5:0]                node_at;
   logic [2:0]                node_lvl;

   string morse_tree = "#EISH54V#3UF####2ARL#####WP##J#1TNDB6#X##KC##Y##MGZ7#Q##O#8##90";

   mkd_pkg::result_type awaited[$];
   mkd_pkg::result_type head;
   int                  mismatches;
   int                  ticks_sent;
   int                  cycles;
   int                  send_idle_pct;
   int                  stall_pct;

   key_row_type script [27] = '{
      '{1'b0, DL, 16'd0, 1'b0, 1'b0, 1'b1, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b0, 1'b1, 1'b1, QUIET_TICK},
      '{1'b1, DL, 16'd2, 1'b0, 1'b0, 1'b0, QUIET_TICK},
      '{1'b1, LG, 16'd2, 1'b0, 1'b0, 1'b0, QUIET_TICK},
      '{1'b1, WG, 16'd2, 1'b0, 1'b0, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b1, 1'b1, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b0, 1'b1, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b1, 1'b0, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b0, 1'b1, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b1, 1'b0, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b0, 1'b1, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b1, 1'b0, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b0, 1'b1, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b1, 1'b0, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b0, 1'b1, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b1, 1'b0, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b0, 1'b1, 1'b1, OVERFLOW_DOT},
      '{1'b0, DL, 16'd0, 1'b0, 1'b0, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b0, 1'b0, 1'b1, ROOT_LETTER},
      '{1'b0, DL, 16'd0, 1'b0, 1'b0, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b1, 1'b0, 1'b1, WORD_END},
      '{1'b0, DL, 16'd0, 1'b1, 1'b0, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b1, 1'b0, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b0, 1'b1, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b1, 1'b1, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b0, 1'b0, 1'b0, QUIET_TICK},
      '{1'b0, DL, 16'd0, 1'b1, 1'b0, 1'b0, QUIET_TICK}
   };

   morse_key_decoder u_top (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic mkd_pkg::result_type decode_tick(bit down, bit up);
      mkd_pkg::event_type  ev;
      mkd_pkg::status_type st;
      logic [6:0]          ch;
      byte                 tree_byte;
      ev = mkd_pkg::EV_NONE;
      st = mkd_pkg::ST_NONE;
      ch = '0;
      unique case (kp_phase)
         mkd_pkg::PH_WAIT_WORD: begin
            word_left = word_left - 16'd1;
            if (word_left == '0) begin
               ev = mkd_pkg::EV_WORD;
               kp_phase = mkd_pkg::PH_IDLE_WORD;
            end else if (down) begin
               press_left = dot_lim;
               kp_phase = mkd_pkg::PH_SHORT;
            end
         end
         mkd_pkg::PH_WAIT_LETTER: begin
            letter_left = letter_left - 16'd1;
            if (letter_left == '0) begin
               ev = mkd_pkg::EV_LETTER;
               kp_phase = mkd_pkg::PH_WAIT_WORD;
            end else if (down) begin
               press_left = dot_lim;
               kp_phase = mkd_pkg::PH_SHORT;
            end
         end
         mkd_pkg::PH_SHORT: begin
            press_left = press_left - 16'd1;
            if (press_left == '0) begin
               kp_phase = mkd_pkg::PH_LONG;
            end else if (up) begin
               word_left = wrd_gap;
               letter_left = let_gap;
               ev = mkd_pkg::EV_DOT;
               kp_phase = mkd_pkg::PH_WAIT_LETTER;
            end
         end
         mkd_pkg::PH_LONG: begin
            if (up) begin
               word_left = wrd_gap;
               letter_left = let_gap;
               ev = mkd_pkg::EV_DASH;
               kp_phase = mkd_pkg::PH_WAIT_LETTER;
            end
         end
         default: begin
            if (down) begin
               press_left = dot_lim;
               kp_phase = mkd_pkg::PH_SHORT;
            end
         end
      endcase

      if (ev == mkd_pkg::EV_DOT || ev == mkd_pkg::EV_DASH) begin
         if (int'(node_lvl) + 1 >= TREE_LEVELS) begin
            st = mkd_pkg::ST_ERROR;
            ch = mkd_pkg::BAD_CHAR;
            node_at = '0;
            node_lvl = '0;
         end else begin
            // A dot moves to the next preorder entry; a dash skips the left subtree.
            if (ev == mkd_pkg::EV_DOT)
               node_at = node_at + 6'd1;
            else
               node_at = node_at + 6'(1 << (TREE_LEVELS - 1 - int'(node_lvl)));
            node_lvl = node_lvl + 3'd1;
            st = mkd_pkg::ST_VALID;
         end
      end else if (ev == mkd_pkg::EV_LETTER) begin
         tree_byte = (int'(node_at) < morse_tree.len()) ? morse_tree[node_at]
                                                        : byte'({1'b0, mkd_pkg::BAD_CHAR});
         if (tree_byte[6:0] == mkd_pkg::BAD_CHAR) begin
            st = mkd_pkg::ST_ERROR;
            ch = mkd_pkg::BAD_CHAR;
         end else begin
            st = mkd_pkg::ST_CHAR;
            ch = tree_byte[6:0];
         end
         node_at = '0;
         node_lvl = '0;
      end
      return '{ev, st, ch};
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer
   // with valid still high, so the next tick can follow without a gap.
   task automatic send_tick(bit down, bit up, bit use_typed,
                            mkd_pkg::result_type typed_res);
      mkd_pkg::result_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.key_pressed <= down;
      req_ch.key_released <= up;
      do
         @(posedge clock);
      while (!req_ch.ready);
      pred = decode_tick(down, up);
      awaited.push_back(use_typed ? typed_res : pred);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (awaited.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [mkd_pkg::CSR_INDEX_W-1:0] idx,
                            logic [mkd_pkg::CFG_W-1:0] val);
      settle();
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      unique case (idx)
         mkd_pkg::CSR_DOT_LIMIT:  dot_lim = val;
         mkd_pkg::CSR_LETTER_GAP: let_gap = val;
         mkd_pkg::CSR_WORD_GAP:   wrd_gap = val;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Mostly well-formed pulses with random hold and gap lengths around the
   // current timer settings, mixed with random noise ticks.
   task automatic run_keying(int count);
      int stop_at;
      int hold_max;
      int short_max;
      int long_max;
      int gap;
      stop_at = ticks_sent + count;
      hold_max = (int'(dot_lim) > 7) ? 8 : int'(dot_lim) + 1;
      short_max = (int'(let_gap) < 2) ? 0 : int'(let_gap) - 2;
      if (short_max > 10)
         short_max = 10;
      long_max = int'(let_gap) + int'(wrd_gap) + 1;
      if (long_max > 14)
         long_max = 14;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(9) == 0) begin
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0);
         end else begin
            send_tick(1'b1, $urandom_range(3) == 0, 1'b0, '0);
            repeat ($urandom_range(hold_max))
               send_tick($urandom_range(7) == 0, 1'b0, 1'b0, '0);
            send_tick($urandom_range(3) == 0, 1'b1, 1'b0, '0);
            if ($urandom_range(99) < 65)
               gap = int'($urandom_range(short_max));
            else
               gap = int'($urandom_range(long_max + 2));
            repeat (gap)
               send_tick(1'b0, $urandom_range(7) == 0, 1'b0, '0);
         end
      end
   endtask

   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited.size() == 0) begin
            $display("%0t: unexpected transfer: event %0d status %0d char %0d", $time,
                     rsp_ch.key_event, rsp_ch.decode_status, rsp_ch.decoded_char);
            mismatches++;
         end else begin
            head = awaited.pop_front();
            if (rsp_ch.key_event !== head.key_event) begin
               $display("%0t: key_event expected %0d actual %0d", $time,
                        head.key_event, rsp_ch.key_event);
               mismatches++;
            end
            if (rsp_ch.decode_status !== head.decode_status) begin
               $display("%0t: decode_status expected %0d actual %0d", $time,
                        head.decode_status, rsp_ch.decode_status);
               mismatches++;
            end
            if (rsp_ch.decoded_char !== head.decoded_char) begin
               $display("%0t: decoded_char expected %0d actual %0d", $time,
                        head.decoded_char, rsp_ch.decoded_char);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, awaited.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.key_pressed = 1'b0;
      req_ch.key_released = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_write_en = 1'b0;
      csr_index = mkd_pkg::CSR_DOT_LIMIT;
      csr_wdata = '0;
      cycles = 0;
      mismatches = 0;
      ticks_sent = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      dot_lim = 16'd25;
      let_gap = 16'd50;
      wrd_gap = 16'd100;
      kp_phase = mkd_pkg::PH_IDLE_WORD;
      press_left = '0;
      letter_left = '0;
      word_left = '0;
      node_at = '0;
      node_lvl = '0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      stall_pct = 58;
      foreach (script[i]) begin
         if (script[i].csr)
            write_reg(script[i].idx, script[i].val);
         else
            send_tick(script[i].down, script[i].up, script[i].typed, script[i].want);
      end
      run_keying(150);
      write_reg(mkd_pkg::CSR_DOT_LIMIT, 16'd3);
      write_reg(mkd_pkg::CSR_LETTER_GAP, 16'd4);
      write_reg(mkd_pkg::CSR_WORD_GAP, 16'd3);
      run_keying(150);
      // Hold off the sender until the result channel has fully drained.
      settle();
      run_keying(150);

      send_idle_pct = 58;
      stall_pct = 20;
      write_reg(mkd_pkg::CSR_DOT_LIMIT, 16'd1);
      write_reg(mkd_pkg::CSR_LETTER_GAP, 16'd1);
      write_reg(mkd_pkg::CSR_WORD_GAP, 16'd1);
      run_keying(150);
      // A zero dot limit wraps, so every pulse here ends as a dot.
      write_reg(mkd_pkg::CSR_DOT_LIMIT, 16'd0);
      write_reg(mkd_pkg::CSR_LETTER_GAP, 16'hFFFF);
      write_reg(mkd_pkg::CSR_WORD_GAP, 16'hFFFF);
      run_keying(100);
      write_reg(mkd_pkg::CSR_DOT_LIMIT, 16'hFFFF);
      write_reg(mkd_pkg::CSR_LETTER_GAP, 16'd3);
      run_keying(60);

      send_idle_pct = 0;
      stall_pct = 0;
      write_reg(mkd_pkg::CSR_DOT_LIMIT, 16'd2);
      write_reg(mkd_pkg::CSR_LETTER_GAP, 16'd6);
      write_reg(mkd_pkg::CSR_WORD_GAP, 16'd5);
      run_keying(450);

      settle();
      if (mismatches == 0 && awaited.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
